[rtl/alsi_pkg.sv]
package alsi_pkg;

    // Request kinds carried in s_axis_tuser
    typedef enum logic [2:0] {
        ACT_APPEND        = 3'd0,
        ACT_PUSH_FRONT    = 3'd1,
        ACT_POP_END       = 3'd2,
        ACT_POP_FRONT     = 3'd3,
        ACT_SORTED_INSERT = 3'd4,
        ACT_REMOVE_VALUE  = 3'd5,
        ACT_SEARCH        = 3'd6,
        ACT_NOP           = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHR_RD,
        S_SHR_WR,
        S_PUT,
        S_SHL_RD,
        S_SHL_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_CLR,
        PTR_INC,
        PTR_COUNT
    } ptr_op_t;

    typedef enum logic [2:0] {
        WI_HOLD,
        WI_COUNT,
        WI_PTR,
        WI_ZERO,
        WI_INC,
        WI_DEC
    } walk_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PTR,
        RD_WALK_DEC,
        RD_WALK_INC
    } rd_sel_t;

    typedef enum logic [1:0] {
        MW_NONE,
        MW_SHIFT,
        MW_PUT
    } mem_wr_t;

    typedef struct packed {
        logic     capture;
        ptr_op_t  ptr_op;
        walk_op_t walk_op;
        cnt_op_t  cnt_op;
        rd_sel_t  rd_sel;
        mem_wr_t  mem_wr;
        logic     set_status;
        status_t  status;
        logic     set_found;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        action_t act;
        logic    full;
        logic    empty;
        logic    scan_end;
        logic    less;
        logic    equal;
        logic    shr_end;
        logic    shl_end;
        logic    out_free;
    } dp_stat_t;

    localparam logic [4:0] IDX_NONE = 5'b11111;

endpackage

[rtl/alsi_ctrl.sv]
module alsi_ctrl
    import alsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  action_t  in_action,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   hit;

    // sorted insert stops at the first larger element, the others at an equal one
    assign hit = (stat.act == ACT_SORTED_INSERT) ? stat.less : stat.equal;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_action)
                        ACT_APPEND, ACT_PUSH_FRONT:
                            state_next = stat.full ? S_DONE : S_SHR_RD;
                        ACT_POP_FRONT:
                            state_next = stat.empty ? S_DONE : S_SHL_RD;
                        ACT_SORTED_INSERT:
                            state_next = stat.full ? S_DONE : S_SCAN_RD;
                        ACT_REMOVE_VALUE:
                            state_next = stat.empty ? S_DONE : S_SCAN_RD;
                        ACT_SEARCH:
                            state_next = S_SCAN_RD;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (!stat.scan_end)
                    state_next = S_SCAN_CMP;
                else if (stat.act == ACT_SORTED_INSERT)
                    state_next = S_SHR_RD;
                else
                    state_next = S_DONE;
            end
            S_SCAN_CMP:
            begin
                if (!hit)
                    state_next = S_SCAN_RD;
                else if (stat.act == ACT_SORTED_INSERT)
                    state_next = S_SHR_RD;
                else if (stat.act == ACT_REMOVE_VALUE)
                    state_next = S_SHL_RD;
                else
                    state_next = S_DONE;
            end
            S_SHR_RD:  state_next = stat.shr_end ? S_PUT : S_SHR_WR;
            S_SHR_WR:  state_next = S_SHR_RD;
            S_PUT:     state_next = S_DONE;
            S_SHL_RD:  state_next = stat.shl_end ? S_DONE : S_SHL_WR;
            S_SHL_WR:  state_next = S_SHL_RD;
            S_DONE:    state_next = stat.out_free ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.ptr_op     = PTR_HOLD;
        cmd.walk_op    = WI_HOLD;
        cmd.cnt_op     = CNT_HOLD;
        cmd.rd_sel     = RD_NONE;
        cmd.mem_wr     = MW_NONE;
        cmd.status     = ST_OK;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture    = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.ptr_op     = (in_action == ACT_APPEND) ? PTR_COUNT : PTR_CLR;
                    case (in_action)
                        ACT_APPEND, ACT_PUSH_FRONT, ACT_SORTED_INSERT:
                        begin
                            if (stat.full)
                                cmd.status = ST_FULL;
                            cmd.walk_op = WI_COUNT;
                        end
                        ACT_POP_END:
                        begin
                            if (stat.empty)
                                cmd.status = ST_EMPTY;
                            else
                                cmd.cnt_op = CNT_DEC;
                        end
                        ACT_POP_FRONT, ACT_REMOVE_VALUE:
                        begin
                            if (stat.empty)
                                cmd.status = ST_EMPTY;
                            cmd.walk_op = WI_ZERO;
                        end
                        default:
                            cmd.status = ST_OK;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (!stat.scan_end)
                    cmd.rd_sel = RD_PTR;
                else if (stat.act == ACT_SORTED_INSERT)
                    cmd.walk_op = WI_COUNT;
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                end
            end
            S_SCAN_CMP:
            begin
                if (!hit)
                    cmd.ptr_op = PTR_INC;
                else if (stat.act == ACT_SORTED_INSERT)
                    cmd.walk_op = WI_COUNT;
                else if (stat.act == ACT_REMOVE_VALUE)
                    cmd.walk_op = WI_PTR;
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_OK;
                    cmd.set_found  = 1'b1;
                end
            end
            S_SHR_RD:
            begin
                if (!stat.shr_end)
                    cmd.rd_sel = RD_WALK_DEC;
            end
            S_SHR_WR:
            begin
                cmd.mem_wr  = MW_SHIFT;
                cmd.walk_op = WI_DEC;
            end
            S_PUT:
            begin
                cmd.mem_wr = MW_PUT;
                cmd.cnt_op = CNT_INC;
            end
            S_SHL_RD:
            begin
                if (stat.shl_end)
                    cmd.cnt_op = CNT_DEC;
                else
                    cmd.rd_sel = RD_WALK_INC;
            end
            S_SHL_WR:
            begin
                cmd.mem_wr  = MW_SHIFT;
                cmd.walk_op = WI_INC;
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

[rtl/alsi_dp.sv]
module alsi_dp
    import alsi_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  in_action,
    input  logic [31:0] in_value,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [31:0]        mem [CAPACITY];
    logic [31:0]        rdata_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      ptr_next;
    logic [CW-1:0]      walk_reg;
    logic [CW-1:0]      walk_next;
    logic [CW-1:0]      walk_dec;
    logic [CW-1:0]      walk_inc;
    logic signed [31:0] value_reg;
    action_t            action_reg;
    status_t            status_reg;
    logic               found_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    logic [CW-1:0]      rd_addr;
    logic [4:0]         idx_field;
    logic               full_now;

    assign walk_dec = walk_reg - CW'(1);
    assign walk_inc = walk_reg + CW'(1);
    assign full_now = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        case (cmd.ptr_op)
            PTR_CLR:   ptr_next = '0;
            PTR_INC:   ptr_next = ptr_reg + CW'(1);
            PTR_COUNT: ptr_next = count_reg;
            default:   ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.walk_op)
            WI_COUNT: walk_next = count_reg;
            WI_PTR:   walk_next = ptr_reg;
            WI_ZERO:  walk_next = '0;
            WI_INC:   walk_next = walk_inc;
            WI_DEC:   walk_next = walk_dec;
            default:  walk_next = walk_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_WALK_DEC: rd_addr = walk_dec;
            RD_WALK_INC: rd_addr = walk_inc;
            default:     rd_addr = ptr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_sel != RD_NONE)
            rdata_reg <= mem[rd_addr[AW-1:0]];
        case (cmd.mem_wr)
            MW_SHIFT: mem[walk_reg[AW-1:0]] <= rdata_reg;
            MW_PUT:   mem[ptr_reg[AW-1:0]]  <= value_reg;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign idx_field = found_reg ? 5'(ptr_reg) : IDX_NONE;

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        walk_reg <= walk_next;
        if (cmd.capture)
        begin
            value_reg  <= in_value;
            action_reg <= action_t'(in_action);
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
            found_reg  <= cmd.set_found;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {2'b00, (count_reg == '0), full_now, 5'(count_reg),
                             idx_field, status_reg};
        end
    end

    assign stat.act      = action_reg;
    assign stat.full     = full_now;
    assign stat.empty    = (count_reg == '0);
    assign stat.scan_end = (ptr_reg == count_reg);
    assign stat.less     = (value_reg < $signed(rdata_reg));
    assign stat.equal    = (value_reg == $signed(rdata_reg));
    assign stat.shr_end  = (walk_reg == ptr_reg);
    assign stat.shl_end  = ((CW+1)'(walk_reg) + (CW+1)'(1)) >= (CW+1)'(count_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1))
        || (count_reg == $past(count_reg) - CW'(1)))
        else $error("element count moved by more than one");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_wr == MW_SHIFT) |-> (walk_reg < CW'(CAPACITY)))
        else $error("shift write outside the store");

    a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_wr == MW_PUT) |-> (!full_now && (ptr_reg <= count_reg)))
        else $error("insert into a full list or past its end");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule

[rtl/array_list_sorted_insert_top.sv]
// Sequential array list: a fixed-capacity list of signed 32-bit values kept
// contiguous in a store of CAPACITY words. Each input transfer is one
// request (append, push front, pop end, pop front, sorted insert, remove value,
// search) and yields exactly one result transfer with status, found index (-1
// unless a search hits), count after the request and full/empty flags. Sorted
// insert places the value after any equal elements and appends it when no element
// is larger. Requests are handled one at a time: the store has one read and one
// write port with registered read data, so every element visited takes a read
// state and then a compare or write state. Append, pop end and any rejected
// request (full, empty, unused code) visit no element; push front shifts the
// whole list up and pop front shifts it down; search and remove value scan from
// the front (remove value then shifts the tail down); sorted insert scans up to
// the insertion point, then shifts the tail up. A finished result sits in an
// output register, so the next request is taken while the previous result waits
// for m_axis_tready. No clearing pass runs after reset; the list starts empty.
module array_list_sorted_insert_top
    import alsi_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [1:0] status, [6:2] found_index,
                                        // [11:7] count, [12] is_full,
                                        // [13] is_empty, [15:14] zero
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: sequences scan, shift and insert steps for each request
    alsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (action_t'(s_axis_tuser)),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: element store, count, scan/shift pointers and result register
    alsi_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_action (s_axis_tuser),
        .in_value  (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
